// ----- sv/bsmv_pkg.sv -----
package bsmv_pkg;

    // Sizes of the storage.
    localparam int MAX_BLOCK    = 8;
    localparam int VECTOR_DEPTH = 4096;
    localparam int QUEUE_DEPTH  = 4;

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int ROW_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SIZE_W = $clog2(MAX_BLOCK + 1);

    // Fixed widths of the channel fields and the register.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 12;
    localparam int INNER_W  = 3;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 4;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 16;

    // Operation codes on the input channel.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_W-1:0] OP_ROWEND = 2'd2;

    localparam logic signed [ACC_W-1:0]  ROUND_HALF = 64'sd32768;
    localparam logic signed [DATA_W-1:0] SAT_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN    = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_COEF,
        CMD_ROWEND
    } cmd_kind_t;

    // One classified command as it travels through the queue.
    typedef struct packed {
        cmd_kind_t                  kind;
        logic [ADDR_W-1:0]          addr;
        logic [ROW_W-1:0]           row;
        logic signed [DATA_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Block size clamped to the supported range.
    function automatic logic [SIZE_W-1:0] size_in_use(input logic [CFG_W-1:0] bs);
        logic [SIZE_W-1:0] n;
        if (bs == '0)
            n = SIZE_W'(1);
        else if (int'(bs) > MAX_BLOCK)
            n = SIZE_W'(MAX_BLOCK);
        else
            n = SIZE_W'(bs);
        return n;
    endfunction

    // Saturate a 64-bit accumulator to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-DATA_W:0] top;
        logic signed [DATA_W-1:0] r;
        top = acc[ACC_W-1:DATA_W-1];
        if (top == '0 || top == '1)
            r = acc[DATA_W-1:0];
        else if (acc[ACC_W-1])
            r = SAT_MIN;
        else
            r = SAT_MAX;
        return r;
    endfunction

endpackage

// ----- sv/bsmv_ram.sv -----
module bsmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem_reg[addr] <= wdata;
            else
                rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bsmv_fifo.sv -----
module bsmv_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bsmv_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output bsmv_pkg::cmd_t        pop_cmd,
    output bsmv_pkg::q_status_t   status
);

    import bsmv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(QUEUE_DEPTH)) && !(push && status.full && !pop))
        else $error("command queue overrun");

endmodule

// ----- sv/bsmv_front.sv -----
module bsmv_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [bsmv_pkg::OP_W-1:0]             operation,
    input  logic [bsmv_pkg::INDEX_W-1:0]          vector_index,
    input  logic [bsmv_pkg::INDEX_W-1:0]          block_col,
    input  logic [bsmv_pkg::INNER_W-1:0]          row_in_block,
    input  logic [bsmv_pkg::INNER_W-1:0]          col_in_block,
    input  logic signed [bsmv_pkg::DATA_W-1:0]    value,
    input  logic [bsmv_pkg::SIZE_W-1:0]           n_size,
    output logic                                  push,
    output bsmv_pkg::cmd_t                        push_cmd,
    input  bsmv_pkg::q_status_t                   q_status
);

    import bsmv_pkg::*;

    localparam int CA_W = INDEX_W + SIZE_W;

    logic            fr_vld_reg, fr_vld_next;
    cmd_t            fr_cmd_reg;
    cmd_t            cmd;
    logic            keep;
    logic            accept;
    logic [CA_W-1:0] coef_addr;

    assign in_stall = fr_vld_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = fr_vld_reg && !q_status.full;
    assign push_cmd = fr_cmd_reg;

    // Column address wraps modulo the store depth through the truncation below.
    assign coef_addr = CA_W'(block_col) * CA_W'(n_size) + CA_W'(col_in_block);

    always_comb
    begin
        cmd.kind  = CMD_LOAD;
        cmd.addr  = ADDR_W'(vector_index);
        cmd.row   = ROW_W'(row_in_block);
        cmd.value = value;
        keep      = 1'b0;
        unique case (operation)
            OP_LOAD:
            begin
                keep = 1'b1;
            end
            OP_COEF:
            begin
                cmd.kind = CMD_COEF;
                cmd.addr = ADDR_W'(coef_addr);
                keep     = (SIZE_W'(row_in_block) < n_size) && (SIZE_W'(col_in_block) < n_size);
            end
            OP_ROWEND:
            begin
                cmd.kind = CMD_ROWEND;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            fr_vld_next = keep;
        else if (push)
            fr_vld_next = 1'b0;
        else
            fr_vld_next = fr_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_vld_reg <= 1'b0;
        else
            fr_vld_reg <= fr_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fr_cmd_reg <= cmd;
    end

endmodule

// ----- sv/bsmv_back.sv -----
module bsmv_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bsmv_pkg::q_status_t                   q_status,
    output logic                                  pop,
    input  bsmv_pkg::cmd_t                        pop_cmd,
    input  logic [bsmv_pkg::SIZE_W-1:0]           n_size,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [bsmv_pkg::DATA_W-1:0]    out_value,
    output logic [bsmv_pkg::INNER_W-1:0]          row_offset,
    output logic                                  last
);

    import bsmv_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [ROW_W-1:0]         k_reg, k_next;

    // Multiply and accumulate pipeline: B has the read data, C the product,
    // D the rounded term.
    logic                     b_vld_reg, c_vld_reg, d_vld_reg;
    logic [ROW_W-1:0]         b_row_reg, c_row_reg, d_row_reg;
    logic signed [DATA_W-1:0] b_value_reg;
    logic signed [ACC_W-1:0]  c_prod_reg, d_term_reg;
    logic signed [ACC_W-1:0]  acc_reg [MAX_BLOCK];

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [ROW_W-1:0]         out_off_reg;
    logic                     out_last_reg;

    logic                     pipe_busy;
    logic                     out_free;
    logic                     emit_fire;
    logic                     k_last;
    logic                     clear_all;
    logic [ROW_W-1:0]         acc_idx;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [ACC_W-1:0]  mult;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [DATA_W-1:0] ram_rdata;
    logic                     ram_en;
    logic                     ram_we;
    logic                     acc_zero;

    bsmv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (pop_cmd.addr),
        .wdata (pop_cmd.value),
        .rdata (ram_rdata)
    );

    assign pipe_busy = b_vld_reg || c_vld_reg || d_vld_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_RUN) && !q_status.empty
                       && ((pop_cmd.kind != CMD_ROWEND) || !pipe_busy);
    assign ram_en    = pop && ((pop_cmd.kind == CMD_LOAD) || (pop_cmd.kind == CMD_COEF));
    assign ram_we    = (pop_cmd.kind == CMD_LOAD);
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign k_last    = (SIZE_W'(k_reg) + SIZE_W'(1)) == n_size;
    assign clear_all = emit_fire && k_last;

    // Stage D and the emission never overlap, so one read index serves both.
    assign acc_idx = (state_reg == ST_EMIT) ? k_reg : d_row_reg;
    assign acc_rd  = acc_reg[acc_idx];

    assign mult = b_value_reg * ram_rdata;
    assign rnd  = c_prod_reg + ROUND_HALF;

    always_comb
    begin
        acc_zero = 1'b1;
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            if (acc_reg[i] != '0)
                acc_zero = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (pop && (pop_cmd.kind == CMD_ROWEND))
                begin
                    state_next = ST_EMIT;
                    k_next     = '0;
                end
            end
            ST_EMIT:
            begin
                if (clear_all)
                    state_next = ST_RUN;
                else if (emit_fire)
                    k_next = k_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            k_reg         <= '0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_off_reg   <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < MAX_BLOCK; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            b_vld_reg     <= pop && (pop_cmd.kind == CMD_COEF);
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            out_valid_reg <= out_valid_next;
            if (emit_fire)
            begin
                out_value_reg <= sat32(acc_rd);
                out_off_reg   <= k_reg;
                out_last_reg  <= k_last;
            end
            if (clear_all)
            begin
                for (int i = 0; i < MAX_BLOCK; i++)
                    acc_reg[i] <= '0;
            end
            else if (d_vld_reg)
            begin
                acc_reg[d_row_reg] <= acc_rd + d_term_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_row_reg   <= pop_cmd.row;
        b_value_reg <= pop_cmd.value;
        c_row_reg   <= b_row_reg;
        c_prod_reg  <= mult;
        d_row_reg   <= c_row_reg;
        d_term_reg  <= rnd >>> FRAC_W;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign row_offset = INNER_W'(out_off_reg);
    assign last       = out_last_reg;

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> !pipe_busy)
        else $error("result emitted while products are still in flight");

    a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> ((SIZE_W'(out_off_reg) + SIZE_W'(1)) == n_size))
        else $error("last flag on the wrong row offset");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> acc_zero)
        else $error("accumulators not cleared after row end");

endmodule

// ----- sv/block_sparse_matrix_vector_multiply.sv -----
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------------
// input     | in_valid / in_stall        | operation, vector_index, block_col,
//           |                            | row_in_block, col_in_block, value
// output    | out_valid / out_stall      | out_value, row_offset, last
// config    | blk_edge_we                | blk_edge_data
//
// Loads and coefficients are taken at one per cycle unless the input stalls; each passes
// a front register and the command queue, and each coefficient a three-stage read,
// multiply, round and accumulate pipeline. A row end waits for it to drain, then gives
// one output transfer per row of the block, one per cycle unless the output stalls.
// Reset is asynchronous and active low; the block size returns to 1, accumulators to zero.
// The vector store is not cleared; the user must load entries before reading (unchecked).
module block_sparse_matrix_vector_multiply (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [bsmv_pkg::OP_W-1:0]             operation,
    input  logic [bsmv_pkg::INDEX_W-1:0]          vector_index,
    input  logic [bsmv_pkg::INDEX_W-1:0]          block_col,
    input  logic [bsmv_pkg::INNER_W-1:0]          row_in_block,
    input  logic [bsmv_pkg::INNER_W-1:0]          col_in_block,
    input  logic signed [bsmv_pkg::DATA_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [bsmv_pkg::DATA_W-1:0]    out_value,
    output logic [bsmv_pkg::INNER_W-1:0]          row_offset,
    output logic                                  last,
    input  logic                                  blk_edge_we,
    input  logic [bsmv_pkg::CFG_W-1:0]            blk_edge_data
);

    import bsmv_pkg::*;

    logic [CFG_W-1:0]  blk_edge_reg;
    logic [SIZE_W-1:0] n_size;
    logic              push;
    logic              pop;
    cmd_t              push_cmd;
    cmd_t              pop_cmd;
    q_status_t         q_status;

    // The user must change the block size only while the block is idle; the block does not
    // enforce this itself. Given that, both halves may read the clamped value directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blk_edge_reg <= CFG_W'(1);
        else if (blk_edge_we)
            blk_edge_reg <= blk_edge_data;
    end

    assign n_size = size_in_use(blk_edge_reg);

    // The front end classifies each transfer, drops coefficients outside the
    // block and unknown operations, and works out the vector address.
    bsmv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .vector_index (vector_index),
        .block_col    (block_col),
        .row_in_block (row_in_block),
        .col_in_block (col_in_block),
        .value        (value),
        .n_size       (n_size),
        .push         (push),
        .push_cmd     (push_cmd),
        .q_status     (q_status)
    );

    // A short queue decouples the front end from the arithmetic, so the input
    // keeps flowing while a row end is being emitted, until the queue is full.
    bsmv_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // The back end owns the vector store, so loads and reads stay in order.
    bsmv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .n_size     (n_size),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .row_offset (row_offset),
        .last       (last)
    );

endmodule

// ----- bench/tb_block_sparse_matrix_vector_multiply.sv -----
// Self-checking bench for the block-CSR sparse matrix times vector engine.
//
// Items are sent on the input channel by one task, and every accepted input transfer is
// also fed to a predictor in this file. The predictor keeps its own copy of the vector
// store, the per-row sums and the block size. Each row end that it sees queues the
// results that the engine ought to return. Every output transfer is checked against the
// oldest queued result, field by field.
//
// The directed tests come first: an empty row straight after reset, products at the
// extremes of Q16.16 (both saturation limits, the exact limits and rounding of halves),
// coefficients that fall outside the block, block sizes that must be clamped, and a size
// change between the coefficients of a row and its row end. A back-pressure test then
// holds the output off for a long stretch while the input keeps offering transfers. The
// bulk of the run is random block rows of random sizes, with loads and junk items mixed in.
//
// The bench never lets the engine read a vector entry that has not been loaded. Before a
// coefficient is sent, the entry that it addresses is loaded if that has not happened yet.
module tb_block_sparse_matrix_vector_multiply;

    import bsmv_pkg::*;

    // Operation code 3 has no meaning and the engine must drop it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Target for the items sent over the whole run, the directed tests included.
    localparam int ITEM_TARGET  = 460;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum {
        RECV_OPEN,
        RECV_BURSTY,
        RECV_PERIODIC
    } recv_mode_t;

    // One element of a block row's output segment.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [INNER_W-1:0]       offset;
        logic                     last;
    } row_result_t;

    logic                      clk;
    logic                      rst_n           = 1'b0;
    logic                      in_valid        = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           operation       = '0;
    logic [INDEX_W-1:0]        vector_index    = '0;
    logic [INDEX_W-1:0]        block_col       = '0;
    logic [INNER_W-1:0]        row_in_block    = '0;
    logic [INNER_W-1:0]        col_in_block    = '0;
    logic signed [DATA_W-1:0]  value           = '0;
    logic                      out_valid;
    logic                      out_stall       = 1'b0;
    logic signed [DATA_W-1:0]  out_value;
    logic [INNER_W-1:0]        row_offset;
    logic                      last;
    logic                      blk_edge_we     = 1'b0;
    logic [CFG_W-1:0]          blk_edge_data   = '0;

    // Predictor state.
    logic [DATA_W-1:0]         model_vector [0:VECTOR_DEPTH-1];
    logic signed [ACC_W-1:0]   row_sums [0:MAX_BLOCK-1];
    logic [CFG_W-1:0]          model_blk_edge = 4'd1;
    row_result_t               expected_results [$];

    // Stimulus-side bookkeeping.
    bit                        loaded [0:VECTOR_DEPTH-1];
    logic [CFG_W-1:0]          size_now = 4'd1;
    logic [15:0]               sizes_written = '0;
    bit                        valid_high = 1'b0;
    bit                        gaps_on = 1'b0;
    int                        burst_left = 0;

    // Receiver behaviour.
    recv_mode_t                recv_mode = RECV_OPEN;
    int                        hold_request = 0;
    int                        hold_left = 0;
    int                        longest_hold = 0;
    bit                        stall_phase = 1'b0;
    int                        stretch_left = 0;
    int                        period_phase = 0;

    // Counters.
    int                        failures = 0;
    int                        items_sent = 0;
    int                        items_accepted = 0;
    int                        results_seen = 0;
    int                        rows_closed = 0;
    int                        input_stall_cycles = 0;
    int                        cycle_count = 0;

    block_sparse_matrix_vector_multiply u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .vector_index  (vector_index),
        .block_col     (block_col),
        .row_in_block  (row_in_block),
        .col_in_block  (col_in_block),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_value     (out_value),
        .row_offset    (row_offset),
        .last          (last),
        .blk_edge_we   (blk_edge_we),
        .blk_edge_data (blk_edge_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The register only promises sizes 1 to MAX_BLOCK; zero behaves as one and anything
    // larger behaves as the largest block.
    function automatic int size_used(input logic [CFG_W-1:0] reg_value);
        if (reg_value == '0)
            return 1;
        if (int'(reg_value) > MAX_BLOCK)
            return MAX_BLOCK;
        return int'(reg_value);
    endfunction

    // Exact Q32.32 product, rounded half up to Q16.16 and kept at 64 bits.
    function automatic logic signed [ACC_W-1:0] rounded_product(
        input logic signed [DATA_W-1:0] coef,
        input logic signed [DATA_W-1:0] entry
    );
        logic signed [ACC_W-1:0] full;
        full = coef * entry;
        return (full + 64'sd32768) >>> FRAC_W;
    endfunction

    function automatic logic signed [DATA_W-1:0] clip32(input logic signed [ACC_W-1:0] sum);
        if (sum > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (sum < 64'shFFFF_FFFF_8000_0000)
            return 32'sh8000_0000;
        return sum[DATA_W-1:0];
    endfunction

    function automatic void log_failure(input string text);
        failures++;
        if (failures <= 10)
            $display("MISMATCH: %s", text);
    endfunction

    // Applies one accepted input transfer to the predictor.
    function automatic void apply_item(
        input logic [OP_W-1:0]          op,
        input logic [INDEX_W-1:0]       vidx,
        input logic [INDEX_W-1:0]       bcol,
        input logic [INNER_W-1:0]       r,
        input logic [INNER_W-1:0]       c,
        input logic signed [DATA_W-1:0] v
    );
        int          n;
        int          addr;
        row_result_t res;
        n = size_used(model_blk_edge);
        case (op)
            OP_LOAD:
                model_vector[vidx] = v;
            OP_COEF:
                if (int'(r) < n && int'(c) < n)
                begin
                    addr = (int'(bcol) * n + int'(c)) % VECTOR_DEPTH;
                    row_sums[r] = row_sums[r] + rounded_product(v, model_vector[addr]);
                end
            OP_ROWEND:
            begin
                for (int k = 0; k < n; k++)
                begin
                    res.val    = clip32(row_sums[k]);
                    res.offset = INNER_W'(k);
                    res.last   = (k == n - 1);
                    expected_results.push_back(res);
                end
                for (int k = 0; k < MAX_BLOCK; k++)
                    row_sums[k] = '0;
                rows_closed++;
            end
            default:
                ;
        endcase
    endfunction

    initial
    begin
        for (int k = 0; k < VECTOR_DEPTH; k++)
        begin
            model_vector[k] = '0;
            loaded[k] = 1'b0;
        end
        for (int k = 0; k < MAX_BLOCK; k++)
            row_sums[k] = '0;
    end

    // Scoreboard. Everything is sampled at the rising edge, before any of this edge's
    // updates land, so the values seen are the ones the engine saw. The output is checked
    // before the input is predicted; a row end cannot answer at the edge that accepts it.
    always @(posedge clk)
    begin : scoreboard
        row_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    log_failure($sformatf("output transfer %0d (value %0d offset %0d) %s",
                                          results_seen, out_value, row_offset,
                                          "with no row end waiting"));
                else
                begin
                    want = expected_results.pop_front();
                    if (out_value !== want.val || row_offset !== want.offset
                        || last !== want.last)
                        log_failure($sformatf(
                            "result %0d: exp %0d off %0d last %0b, got %0d off %0d last %0b",
                            results_seen, want.val, want.offset, want.last,
                            out_value, row_offset, last));
                end
                results_seen++;
            end
            if (blk_edge_we)
                model_blk_edge = blk_edge_data;
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (in_valid && !in_stall)
            begin
                items_accepted++;
                apply_item(operation, vector_index, block_col, row_in_block, col_in_block, value);
            end
        end
    end

    // Receiver. A long hold-off, once asked for, is counted down here and overrides the
    // current stall pattern.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_request - 1;
            longest_hold = hold_request;
            hold_request = 0;
        end
        else
        begin
            case (recv_mode)
                RECV_BURSTY:
                begin
                    if (stretch_left == 0)
                    begin
                        stall_phase = !stall_phase;
                        stretch_left = stall_phase ? $urandom_range(1, 4) : $urandom_range(1, 6);
                    end
                    stretch_left--;
                    out_stall <= stall_phase;
                end
                RECV_PERIODIC:
                begin
                    period_phase = (period_phase + 1) % 3;
                    out_stall <= (period_phase == 0);
                end
                default:
                    out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog.
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Offers one item and returns at the edge that accepts it. Valid is left high so that
    // transfers can follow back to back; when gaps_on is set, gaps are inserted between bursts.
    task automatic send_item(
        input logic [OP_W-1:0]          op,
        input logic [INDEX_W-1:0]       vidx,
        input logic [INDEX_W-1:0]       bcol,
        input logic [INNER_W-1:0]       r,
        input logic [INNER_W-1:0]       c,
        input logic signed [DATA_W-1:0] v
    );
        if (gaps_on && burst_left == 0)
        begin
            if (valid_high)
            begin
                in_valid <= 1'b0;
                valid_high = 1'b0;
            end
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        operation    <= op;
        vector_index <= vidx;
        block_col    <= bcol;
        row_in_block <= r;
        col_in_block <= c;
        value        <= v;
        in_valid     <= 1'b1;
        valid_high = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic release_input();
        if (valid_high)
        begin
            in_valid <= 1'b0;
            valid_high = 1'b0;
            @(posedge clk);
        end
    endtask

    // Waits until every queued result has arrived, then lets trailing loads and
    // coefficients leave the pipeline before the register may be touched.
    task automatic drain_and_wait();
        release_input();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_blk_edge(input logic [CFG_W-1:0] sz);
        blk_edge_data <= sz;
        blk_edge_we   <= 1'b1;
        @(posedge clk);
        blk_edge_we   <= 1'b0;
        size_now = sz;
        sizes_written[sz] = 1'b1;
        @(posedge clk);
    endtask

    // Mostly moderate values within +/-16.0, so that sums stay in range, and now and then
    // any 32-bit pattern at all.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int moderate;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        moderate = int'($urandom_range(0, 2097152)) - 1048576;
        return moderate;
    endfunction

    task automatic send_load(input logic [INDEX_W-1:0] addr, input logic signed [DATA_W-1:0] v);
        send_item(OP_LOAD, addr, INDEX_W'($urandom), INNER_W'($urandom), INNER_W'($urandom), v);
        loaded[addr] = 1'b1;
    endtask

    // The entry that the coefficient addresses is loaded first if it never was.
    task automatic send_coef(
        input logic [INDEX_W-1:0]       bcol,
        input logic [INNER_W-1:0]       r,
        input logic [INNER_W-1:0]       c,
        input logic signed [DATA_W-1:0] v
    );
        int addr;
        addr = (int'(bcol) * size_used(size_now) + int'(c)) % VECTOR_DEPTH;
        if (!loaded[addr])
            send_load(INDEX_W'(addr), pick_value());
        send_item(OP_COEF, INDEX_W'($urandom), bcol, r, c, v);
    endtask

    task automatic send_row_end();
        send_item(OP_ROWEND, INDEX_W'($urandom), INDEX_W'($urandom),
                  INNER_W'($urandom), INNER_W'($urandom), $urandom);
    endtask

    task automatic send_junk();
        send_item(OP_UNUSED, INDEX_W'($urandom), INDEX_W'($urandom),
                  INNER_W'($urandom), INNER_W'($urandom), $urandom);
    endtask

    // A row end straight after reset closes an empty row of the reset size, one zero.
    task automatic test_empty_row_after_reset();
        send_row_end();
        send_junk();
        send_row_end();
        drain_and_wait();
    endtask

    // Products at the edges of Q16.16: both saturation limits, both exact limits, and
    // rounding of a positive and a negative half. The coefficient address of the last
    // block column wraps round to the top of the store.
    task automatic test_extreme_products();
        recv_mode = RECV_BURSTY;
        write_blk_edge(4'd8);
        send_load(12'd4095, 32'sh8000_0000);
        send_load(12'd0, 32'sh7FFF_FFFF);
        send_load(12'd1, 32'sh0000_8000);
        send_coef(12'd4095, 3'd0, 3'd7, 32'sh8000_0000);
        send_coef(12'd4095, 3'd1, 3'd7, 32'sh7FFF_FFFF);
        send_coef(12'd0, 3'd2, 3'd1, 32'sh0000_0001);
        send_coef(12'd0, 3'd3, 3'd1, -32'sd1);
        send_coef(12'd0, 3'd4, 3'd0, 32'sh0001_0000);
        send_coef(12'd4095, 3'd5, 3'd7, 32'sh0001_0000);
        send_row_end();
        drain_and_wait();
    endtask

    // With a block of three, a row or column index of three or more must be dropped.
    task automatic test_outside_block();
        gaps_on = 1'b1;
        write_blk_edge(4'd3);
        send_coef(12'd0, 3'd3, 3'd0, 32'sh0004_0000);
        send_coef(12'd0, 3'd0, 3'd5, 32'sh0004_0000);
        send_coef(12'd1, 3'd2, 3'd2, 32'sh0002_8000);
        send_row_end();
        drain_and_wait();
    endtask

    // Zero acts as a block of one; nine and fifteen act as the largest block.
    task automatic test_size_clamping();
        write_blk_edge(4'd0);
        send_coef(12'd4095, 3'd0, 3'd0, 32'sh0002_0000);
        send_row_end();
        drain_and_wait();
        write_blk_edge(4'd15);
        send_row_end();
        drain_and_wait();
        write_blk_edge(4'd9);
        send_row_end();
        drain_and_wait();
    endtask

    // The size at the row end decides how many results come out, and every row sum is
    // cleared, including those beyond the new size.
    task automatic test_size_change_in_row();
        write_blk_edge(4'd8);
        send_coef(12'd2, 3'd6, 3'd3, pick_value());
        send_coef(12'd3, 3'd7, 3'd1, pick_value());
        send_coef(12'd5, 3'd0, 3'd4, pick_value());
        drain_and_wait();
        write_blk_edge(4'd2);
        send_row_end();
        drain_and_wait();
        write_blk_edge(4'd8);
        send_row_end();
        drain_and_wait();
    endtask

    // The output is held off for a long stretch while full rows keep arriving, so the
    // engine fills up and has to stall its input.
    task automatic test_output_hold_off();
        gaps_on = 1'b0;
        recv_mode = RECV_OPEN;
        write_blk_edge(4'd8);
        hold_request = LONG_HOLD;
        repeat (6)
        begin
            repeat (3)
                send_coef(INDEX_W'($urandom_range(0, 7)), INNER_W'($urandom_range(0, 7)),
                          INNER_W'($urandom_range(0, 7)), pick_value());
            send_row_end();
        end
        drain_and_wait();
    endtask

    // Random block rows. Each phase picks a block size and an idling style, then sends a
    // few rows, each a run of coefficients with loads and junk mixed in, closed by a row
    // end. Small block columns reuse loaded entries; large ones make the address wrap.
    task automatic test_random_traffic();
        int                 n;
        int                 dice;
        int                 body;
        logic [CFG_W-1:0]   sz;
        logic [INDEX_W-1:0] bcol;
        logic [INNER_W-1:0] r;
        logic [INNER_W-1:0] c;
        while (items_sent < ITEM_TARGET)
        begin
            drain_and_wait();
            dice = $urandom_range(0, 9);
            if (dice == 0)
                sz = CFG_W'($urandom_range(9, 15));
            else if (dice == 1)
                sz = '0;
            else
                sz = CFG_W'($urandom_range(1, 8));
            write_blk_edge(sz);
            n = size_used(sz);
            gaps_on = ($urandom_range(0, 2) != 0);
            recv_mode = recv_mode_t'($urandom_range(0, 2));
            repeat ($urandom_range(2, 6))
            begin
                // Once the target is reached, the remaining rows of the phase are empty.
                body = (items_sent < ITEM_TARGET) ? int'($urandom_range(0, 10)) : 0;
                repeat (body)
                begin
                    dice = $urandom_range(0, 99);
                    bcol = ($urandom_range(0, 1) == 0) ? INDEX_W'($urandom_range(0, 7))
                                                      : INDEX_W'($urandom);
                    r = INNER_W'($urandom_range(0, n - 1));
                    c = INNER_W'($urandom_range(0, n - 1));
                    if (dice < 12)
                        send_load(INDEX_W'($urandom), pick_value());
                    else if (dice < 15)
                        send_junk();
                    else if (dice < 22 && n < MAX_BLOCK)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            r = INNER_W'($urandom_range(n, MAX_BLOCK - 1));
                        else
                            c = INNER_W'($urandom_range(n, MAX_BLOCK - 1));
                        send_coef(bcol, r, c, pick_value());
                    end
                    else
                        send_coef(bcol, r, c, pick_value());
                end
                send_row_end();
            end
        end
        drain_and_wait();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_row_after_reset();
        test_extreme_products();
        test_outside_block();
        test_size_clamping();
        test_size_change_in_row();
        test_output_hold_off();
        test_random_traffic();

        release_input();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            log_failure($sformatf("%0d results never arrived", expected_results.size()));

        $display("Covered %0d input and %0d output transfers, %0d block rows, %0d sizes",
                 items_accepted, results_seen, rows_closed, $countones(sizes_written));
        $display("Longest output hold-off %0d cycles, input stalled %0d cycles, %0d mismatches",
                 longest_hold, input_stall_cycles, failures);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- block_sparse_matrix_vector_multiply.f -----
sv/bsmv_pkg.sv
sv/bsmv_ram.sv
sv/bsmv_fifo.sv
sv/bsmv_front.sv
sv/bsmv_back.sv
sv/block_sparse_matrix_vector_multiply.sv
bench/tb_block_sparse_matrix_vector_multiply.sv
